[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FDEM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define FDEM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define FDEM_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: reset behavior");

`endif

[hdl/fdem_pkg.sv]
// Types, constants and helpers of the directory entry matcher.
`default_nettype none

package fdem_pkg;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_END       = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] first_cluster;
      logic [31:0] size_bytes;
      logic [15:0] entry_index;
   } rec_type;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_BASE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_EXT  = 2'd1;

   localparam logic [63:0] TARGET_BASE_RESET = 64'h2020_2020_2020_2020;
   localparam logic [23:0] TARGET_EXT_RESET  = 24'h20_2020;

   localparam logic [7:0] BYTE_DELETED  = 8'hE5;
   localparam logic [7:0] BYTE_LONGNAME = 8'h0F;
   localparam logic [7:0] BYTE_END      = 8'h00;

   localparam logic [4:0] POS_FIRST     = 5'd0;
   localparam logic [4:0] POS_NAME_LAST = 5'd10;
   localparam logic [4:0] POS_ATTR      = 5'd11;
   localparam logic [4:0] POS_CLHI_LO   = 5'd20;
   localparam logic [4:0] POS_CLHI_HI   = 5'd21;
   localparam logic [4:0] POS_CLLO_LO   = 5'd26;
   localparam logic [4:0] POS_CLLO_HI   = 5'd27;
   localparam logic [4:0] POS_SIZE_LO   = 5'd28;
   localparam logic [4:0] POS_LAST      = 5'd31;

   localparam int unsigned FQ_DEPTH    = 2;
   localparam int unsigned FQ_PTR_BITS = 1;
   localparam int unsigned FQ_CNT_BITS = 2;

   function automatic logic [7:0] target_byte(input logic [63:0] base,
                                              input logic [23:0] ext,
                                              input logic [3:0]  pos);
      logic [7:0] r;
      if (pos[3] == 1'b0) begin
         r = base[{pos[2:0], 3'b000} +: 8];
      end else begin
         r = ext[{pos[1:0], 3'b000} +: 8];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/fat_directory_entry_matcher_core.sv]
// Top level of the FAT short-name directory entry matcher.
//  channel   direction  handshake        payload
//  req       in         push / full      req_start_req, req_dir_byte, req_last
//  rsp       out        empty / pop      rsp_status, rsp_first_cluster, rsp_size_bytes,
//                                        rsp_entry_index
//  csr       in         csr_we           csr_index, csr_wdata
// One byte is taken per cycle while full is low; the front decides in the transfer cycle.
// A result passes through the queue and then the output register to the rsp ports.
// Two results queue behind the output register; full rises once both slots hold one.
// After reset the block ignores bytes until one arrives with req_start_req set.
`default_nettype none

module fat_directory_entry_matcher_core #(
   parameter int unsigned INDEX_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic                                req_start_req,
   input  wire logic [7:0]                          req_dir_byte,
   input  wire logic                                req_last,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [1:0]                               rsp_status,
   output logic [31:0]                              rsp_first_cluster,
   output logic [31:0]                              rsp_size_bytes,
   output logic [15:0]                              rsp_entry_index,
   input  wire logic                                csr_we,
   input  wire logic [fdem_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [63:0]                         csr_wdata
);

   fdem_pkg::rec_type front_rec, q_rec, out_rec;
   logic              front_valid, q_nonempty, q_full, q_take, accept;

   assign accept = push && !q_full;
   assign full   = q_full;

   fdem_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .start_req (req_start_req),
      .dir_byte  (req_dir_byte),
      .last      (req_last),
      .rec       (front_rec),
      .rec_valid (front_valid)
   );

   fdem_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_rec   (front_rec),
      .rd_en    (q_take),
      .rd_rec   (q_rec),
      .nonempty (q_nonempty),
      .is_full  (q_full)
   );

   fdem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rec      (q_rec),
      .q_nonempty (q_nonempty),
      .q_take     (q_take),
      .pop        (pop),
      .empty      (empty),
      .out_rec    (out_rec)
   );

   assign rsp_status        = out_rec.status;
   assign rsp_first_cluster = out_rec.first_cluster;
   assign rsp_size_bytes    = out_rec.size_bytes;
   assign rsp_entry_index   = out_rec.entry_index;

endmodule

`default_nettype wire

[hdl/fdem_front.sv]
// Front part: takes directory bytes, tracks entries and decides results.
`default_nettype none

module fdem_front #(
   parameter int unsigned INDEX_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic [fdem_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [63:0]                             csr_wdata,
   input  wire logic                                    accept,
   input  wire logic                                    start_req,
   input  wire logic [7:0]                              dir_byte,
   input  wire logic                                    last,
   output fdem_pkg::rec_type                            rec,
   output logic                                         rec_valid
);

   logic [63:0]           base_ff, base_in;
   logic [23:0]           ext_ff, ext_in;
   logic                  done_ff, done_in;
   logic [4:0]            pos_ff, pos_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;
   logic                  mismatch_ff, mismatch_in;
   logic                  skip_ff, skip_in;
   logic [15:0]           clhi_ff, clhi_in;
   logic [15:0]           cllo_ff, cllo_in;
   logic [31:0]           size_ff, size_in;

   logic                  eff_done;
   logic [4:0]            pos;
   logic [INDEX_BITS-1:0] cnt;

   always_comb begin
      base_in = base_ff;
      ext_in  = ext_ff;
      if (csr_we) begin
         case (csr_index)
            fdem_pkg::CSR_TARGET_BASE: base_in = csr_wdata;
            fdem_pkg::CSR_TARGET_EXT:  ext_in  = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_done    = start_req ? 1'b0 : done_ff;
      pos         = start_req ? fdem_pkg::POS_FIRST : pos_ff;
      cnt         = start_req ? '0 : count_ff;
      done_in     = done_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      mismatch_in = mismatch_ff;
      skip_in     = skip_ff;
      clhi_in     = clhi_ff;
      cllo_in     = cllo_ff;
      size_in     = size_ff;
      rec_valid   = 1'b0;
      rec         = '0;
      rec.status  = fdem_pkg::ST_NOT_FOUND;
      if (accept) begin
         done_in  = eff_done;
         pos_in   = pos;
         count_in = cnt;
         if (!eff_done) begin
            if (pos == fdem_pkg::POS_FIRST && dir_byte == fdem_pkg::BYTE_END) begin
               rec_valid       = 1'b1;
               rec.status      = fdem_pkg::ST_END;
               rec.entry_index = 16'(cnt);
               done_in         = 1'b1;
            end else if (pos == fdem_pkg::POS_LAST && !skip_ff && !mismatch_ff) begin
               rec_valid         = 1'b1;
               rec.status        = fdem_pkg::ST_FOUND;
               rec.first_cluster = {clhi_ff, cllo_ff};
               rec.size_bytes    = {dir_byte, size_ff[23:0]};
               rec.entry_index   = 16'(cnt);
               done_in           = 1'b1;
            end else begin
               if (pos == fdem_pkg::POS_FIRST) begin
                  skip_in     = (dir_byte == fdem_pkg::BYTE_DELETED);
                  mismatch_in = (dir_byte != fdem_pkg::target_byte(base_ff, ext_ff, 4'd0));
                  clhi_in     = '0;
                  cllo_in     = '0;
                  size_in     = '0;
               end else if (pos <= fdem_pkg::POS_NAME_LAST) begin
                  if (dir_byte != fdem_pkg::target_byte(base_ff, ext_ff, pos[3:0])) begin
                     mismatch_in = 1'b1;
                  end
               end else if (pos == fdem_pkg::POS_ATTR) begin
                  if (dir_byte == fdem_pkg::BYTE_LONGNAME) begin
                     skip_in = 1'b1;
                  end
               end else if (pos == fdem_pkg::POS_CLHI_LO) begin
                  clhi_in[7:0] = dir_byte;
               end else if (pos == fdem_pkg::POS_CLHI_HI) begin
                  clhi_in[15:8] = dir_byte;
               end else if (pos == fdem_pkg::POS_CLLO_LO) begin
                  cllo_in[7:0] = dir_byte;
               end else if (pos == fdem_pkg::POS_CLLO_HI) begin
                  cllo_in[15:8] = dir_byte;
               end else if (pos >= fdem_pkg::POS_SIZE_LO) begin
                  size_in[{pos[1:0], 3'b000} +: 8] = dir_byte;
               end
               if (pos == fdem_pkg::POS_LAST) begin
                  count_in = cnt + 1'b1;
                  pos_in   = fdem_pkg::POS_FIRST;
               end else begin
                  pos_in = pos + 5'd1;
               end
               if (last) begin
                  rec_valid       = 1'b1;
                  rec.status      = fdem_pkg::ST_NOT_FOUND;
                  rec.entry_index = 16'(count_in);
                  done_in         = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= fdem_pkg::TARGET_BASE_RESET;
         ext_ff   <= fdem_pkg::TARGET_EXT_RESET;
         done_ff  <= 1'b1;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         ext_ff   <= ext_in;
         done_ff  <= done_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
      mismatch_ff <= mismatch_in;
      skip_ff     <= skip_in;
      clhi_ff     <= clhi_in;
      cllo_ff     <= cllo_in;
      size_ff     <= size_in;
   end

endmodule

`default_nettype wire

[hdl/fdem_queue.sv]
// Short result queue between the front and back parts.
`default_nettype none

module fdem_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  fdem_pkg::rec_type wr_rec,
   input  wire logic        rd_en,
   output fdem_pkg::rec_type rd_rec,
   output logic             nonempty,
   output logic             is_full
);

   fdem_pkg::rec_type mem [fdem_pkg::FQ_DEPTH];

   logic [fdem_pkg::FQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fdem_pkg::FQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fdem_pkg::FQ_CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      nonempty  = (cnt_ff != '0);
      is_full   = (cnt_ff == fdem_pkg::FQ_CNT_BITS'(fdem_pkg::FQ_DEPTH));
      rd_rec    = mem[rd_ptr_ff];
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_rec;
      end
   end

endmodule

`default_nettype wire

[hdl/fdem_back.sv]
// Back part: output register that presents the oldest result.
`default_nettype none

module fdem_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  fdem_pkg::rec_type q_rec,
   input  wire logic         q_nonempty,
   output logic              q_take,
   input  wire logic         pop,
   output logic              empty,
   output fdem_pkg::rec_type out_rec
);

   logic              valid_ff, valid_in;
   fdem_pkg::rec_type rec_ff;

   always_comb begin
      q_take   = q_nonempty && (!valid_ff || pop);
      valid_in = q_take || (valid_ff && !pop);
      empty    = !valid_ff;
      out_rec  = rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (q_take) begin
         rec_ff <= q_rec;
      end
   end

endmodule

`default_nettype wire

[hdl/fdem_checker.sv]
// Port-level checker of the matcher and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module fdem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_first_cluster,
   input wire logic [31:0] rsp_size_bytes,
   input wire logic [15:0] rsp_entry_index
);

   logic [81:0] rsp_now;
   logic        rsp_miss;
   logic        rsp_zero;

   assign rsp_now  = {rsp_status, rsp_first_cluster, rsp_size_bytes, rsp_entry_index};
   assign rsp_miss = !empty && (rsp_status != fdem_pkg::ST_FOUND);
   assign rsp_zero = (rsp_first_cluster == 32'd0) && (rsp_size_bytes == 32'd0);

   `FDEM_ASSERT_RST(a_reset_clears, clock, reset, empty && !full)
   `FDEM_ASSERT_NXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_now))
   `FDEM_ASSERT_IMP(a_miss_zero, clock, reset, rsp_miss, rsp_zero)
   `FDEM_ASSERT_IMP(a_full_has_rsp, clock, reset, full, !empty)

endmodule

bind fat_directory_entry_matcher_core fdem_checker u_fdem_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_status        (rsp_status),
   .rsp_first_cluster (rsp_first_cluster),
   .rsp_size_bytes    (rsp_size_bytes),
   .rsp_entry_index   (rsp_entry_index)
);

`default_nettype wire

[bench/search_scoreboard_pkg.sv]
// Search predictor and result checker for the directory entry matcher bench.
package search_scoreboard_pkg;
   import fdem_pkg::*;

   localparam int unsigned SEARCH_COUNT_BITS = 16;

   class search_scoreboard;
      logic [63:0]                  name_base;
      logic [23:0]                  name_ext;
      logic [4:0]                   position;
      logic [SEARCH_COUNT_BITS-1:0] entry_count;
      bit                           name_miss;
      bit                           skip_entry;
      bit                           search_done;
      logic [15:0]                  cl_hi;
      logic [15:0]                  cl_lo;
      logic [31:0]                  size_acc;
      rec_type                      awaited[$];
      int unsigned                  mismatches;

      function new();
         name_base     = TARGET_BASE_RESET;
         name_ext      = TARGET_EXT_RESET;
         mismatches    = 0;
         clear_search();
         search_done   = 1'b1;
      endfunction

      function void clear_search();
         position    = POS_FIRST;
         entry_count = '0;
         name_miss   = 1'b0;
         skip_entry  = 1'b0;
         cl_hi       = '0;
         cl_lo       = '0;
         size_acc    = '0;
      endfunction

      function logic [7:0] target_char(input logic [4:0] pos);
         logic [87:0] name;
         name = {name_ext, name_base};
         return name[8*int'(pos) +: 8];
      endfunction

      function void write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] data);
         case (idx)
            CSR_TARGET_BASE: name_base = data;
            CSR_TARGET_EXT: name_ext = data[23:0];
            default: ;
         endcase
      endfunction

      function void expect_outcome(input status_type st, input logic [31:0] cluster,
                                   input logic [31:0] size);
         rec_type r;
         r.status        = st;
         r.first_cluster = cluster;
         r.size_bytes    = size;
         r.entry_index   = 16'(entry_count);
         awaited.push_back(r);
         search_done = 1'b1;
      endfunction

      function bit scan_byte(input bit start, input logic [7:0] b, input bit last);
         logic [4:0] p;
         if (start) begin
            clear_search();
            search_done = 1'b0;
         end
         if (search_done) begin
            return 1'b0;
         end
         p = position;
         if (p == POS_FIRST) begin
            if (b == BYTE_END) begin
               expect_outcome(ST_END, '0, '0);
               return 1'b1;
            end
            skip_entry = (b == BYTE_DELETED);
            name_miss  = (b != target_char(p));
            cl_hi      = '0;
            cl_lo      = '0;
            size_acc   = '0;
         end else if (p <= POS_NAME_LAST) begin
            if (b != target_char(p)) name_miss = 1'b1;
         end else if (p == POS_ATTR) begin
            if (b == BYTE_LONGNAME) skip_entry = 1'b1;
         end else if (p == POS_CLHI_LO) begin
            cl_hi[7:0] = b;
         end else if (p == POS_CLHI_HI) begin
            cl_hi[15:8] = b;
         end else if (p == POS_CLLO_LO) begin
            cl_lo[7:0] = b;
         end else if (p == POS_CLLO_HI) begin
            cl_lo[15:8] = b;
         end else if (p >= POS_SIZE_LO) begin
            size_acc[8*int'(p - POS_SIZE_LO) +: 8] = b;
         end
         if (p == POS_LAST) begin
            if (!skip_entry && !name_miss) begin
               expect_outcome(ST_FOUND, {cl_hi, cl_lo}, size_acc);
               return 1'b1;
            end
            entry_count++;
            position = POS_FIRST;
         end else begin
            position = p + 5'd1;
         end
         if (last) begin
            expect_outcome(ST_NOT_FOUND, '0, '0);
         end
         return 1'b1;
      endfunction

      task report_mismatch(input string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task check_outcome(input logic [1:0] st, input logic [31:0] cluster,
                         input logic [31:0] size, input logic [15:0] index);
         rec_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: status %0d index %0d",
                                      st, index));
         end else begin
            want = awaited.pop_front();
            if (st !== want.status)
               report_mismatch($sformatf("status: got %0d, want %0d", st, want.status));
            if (cluster !== want.first_cluster)
               report_mismatch($sformatf("first_cluster: got %h, want %h",
                                         cluster, want.first_cluster));
            if (size !== want.size_bytes)
               report_mismatch($sformatf("size_bytes: got %h, want %h", size, want.size_bytes));
            if (index !== want.entry_index)
               report_mismatch($sformatf("entry_index: got %0d, want %0d",
                                         index, want.entry_index));
         end
      endtask
   endclass

endpackage

[bench/testbench.sv]
// Top-level bench: drives directory bytes and register writes, checks search results.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fdem_pkg::*;
   import search_scoreboard_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned BYTE_TARGET   = 600;

   typedef enum {ENT_MATCH, ENT_NEAR, ENT_DELETED, ENT_LONGNAME, ENT_END, ENT_NOISE} entry_kind;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      push          = 1'b0;
   logic                      req_start_req = 1'b0;
   logic [7:0]                req_dir_byte  = 8'h00;
   logic                      req_last      = 1'b0;
   logic                      pop           = 1'b0;
   logic                      csr_we        = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = CSR_TARGET_BASE;
   logic [63:0]               csr_wdata     = 64'h0;
   logic                      full;
   logic                      empty;
   logic [1:0]                rsp_status;
   logic [31:0]               rsp_first_cluster;
   logic [31:0]               rsp_size_bytes;
   logic [15:0]               rsp_entry_index;

   search_scoreboard board;
   bit send_burst   = 1'b0;
   bit take_burst   = 1'b0;
   bit hold_request = 1'b0;
   int unsigned bytes_sent = 0;

   fat_directory_entry_matcher_core #(.INDEX_BITS(SEARCH_COUNT_BITS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_start_req     (req_start_req),
      .req_dir_byte      (req_dir_byte),
      .req_last          (req_last),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_first_cluster (rsp_first_cluster),
      .rsp_size_bytes    (rsp_size_bytes),
      .rsp_entry_index   (rsp_entry_index),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic send_byte(input bit start, input logic [7:0] b, input bit last);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = draw_gap(send_burst);
      if (gap != 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push          = 1'b1;
      req_start_req = start;
      req_dir_byte  = b;
      req_last      = last;
      do @(posedge clock); while (full);
      void'(board.scan_byte(start, b, last));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_entry(input entry_kind kind, input bit first_start,
                             input int unsigned count, input bit last_on_final, input int fill);
      logic [7:0]  image [32];
      int unsigned flip;
      for (int i = 0; i < 32; i++) begin
         image[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      end
      if (kind != ENT_NOISE) begin
         for (int i = 0; i < 11; i++) image[i] = board.target_char(5'(i));
      end
      case (kind)
         ENT_NEAR: begin
            flip = $urandom_range(1, 10);
            image[flip] ^= 8'($urandom_range(1, 255));
         end
         ENT_DELETED: image[POS_FIRST] = BYTE_DELETED;
         ENT_LONGNAME: image[POS_ATTR] = BYTE_LONGNAME;
         ENT_END: image[POS_FIRST] = BYTE_END;
         default: ;
      endcase
      for (int i = 0; i < count; i++) begin
         send_byte(first_start && i == 0, image[i], last_on_final && i == count - 1);
      end
   endtask

   task automatic settle();
      push = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      board.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic retarget();
      logic [63:0] base;
      logic [63:0] ext;
      base = {$urandom, $urandom};
      ext  = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: begin
            base       = TARGET_BASE_RESET;
            ext[23:0]  = TARGET_EXT_RESET;
         end
         1: begin
            base       = '0;
            ext[23:0]  = '0;
         end
         2: begin
            base       = '1;
            ext[23:0]  = '1;
         end
         3: base[7:0] = BYTE_DELETED;
         default: ;
      endcase
      settle();
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE_A, {$urandom, $urandom});
      write_csr(CSR_TARGET_BASE, base);
      write_csr(CSR_TARGET_EXT, ext);
      csr_we = 1'b0;
   endtask

   function automatic entry_kind pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 22) return ENT_MATCH;
      if (r < 47) return ENT_NEAR;
      if (r < 59) return ENT_DELETED;
      if (r < 71) return ENT_LONGNAME;
      if (r < 79) return ENT_END;
      return ENT_NOISE;
   endfunction

   function automatic entry_kind pick_filler();
      case ($urandom_range(0, 2))
         0: return ENT_NEAR;
         1: return ENT_DELETED;
         default: return ENT_LONGNAME;
      endcase
   endfunction

   task automatic run_search();
      int unsigned n;
      int unsigned cnt;
      bit          long_run;
      bit          end_last;
      entry_kind   kind;
      long_run = ($urandom_range(0, 9) == 0);
      n = long_run ? $urandom_range(16, 20) : $urandom_range(1, 5);
      for (int e = 0; e < n; e++) begin
         if (long_run) kind = (e == n - 1) ? ENT_MATCH : pick_filler();
         else kind = pick_kind();
         cnt      = 32;
         end_last = 1'b0;
         if (e == n - 1) begin
            case ($urandom_range(0, 3))
               1: end_last = 1'b1;
               2: begin
                  cnt      = $urandom_range(1, 31);
                  end_last = 1'b1;
               end
               default: ;
            endcase
         end
         send_entry(kind, e == 0, cnt, end_last,
                    ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 0 : 255) : -1);
      end
      repeat ($urandom_range(0, 3)) begin
         send_byte(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         send_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      repeat (3) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_entry(ENT_MATCH, 1'b1, 32, 1'b0, 255);
      send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);

      settle();
      write_csr(CSR_TARGET_BASE, '1);
      write_csr(CSR_TARGET_EXT, '1);
      csr_we = 1'b0;
      send_entry(ENT_MATCH, 1'b1, 32, 1'b0, 0);
      send_entry(ENT_DELETED, 1'b1, 32, 1'b0, -1);
      send_entry(ENT_LONGNAME, 1'b0, 32, 1'b0, -1);
      send_entry(ENT_NEAR, 1'b0, 32, 1'b0, -1);
      send_entry(ENT_MATCH, 1'b0, 32, 1'b1, -1);
      send_entry(ENT_NEAR, 1'b1, 32, 1'b0, -1);
      send_entry(ENT_MATCH, 1'b0, 18, 1'b1, -1);
      send_entry(ENT_NEAR, 1'b1, 32, 1'b0, -1);
      send_entry(ENT_END, 1'b0, 1, 1'b1, -1);
      send_byte(1'b1, 8'h41, 1'b1);
      send_entry(ENT_MATCH, 1'b1, 10, 1'b0, -1);
      send_entry(ENT_MATCH, 1'b1, 32, 1'b0, -1);
      send_entry(ENT_NEAR, 1'b1, 32, 1'b0, -1);
      repeat (2) send_entry(ENT_NEAR, 1'b0, 32, 1'b0, -1);
      send_entry(ENT_MATCH, 1'b0, 32, 1'b0, -1);

      settle();
      write_csr(CSR_SPARE_A, {$urandom, $urandom});
      write_csr(CSR_SPARE_B, {$urandom, $urandom});
      write_csr(CSR_TARGET_BASE, '0);
      write_csr(CSR_TARGET_EXT, '0);
      csr_we = 1'b0;
      send_entry(ENT_MATCH, 1'b1, 32, 1'b0, -1);

      hold_request = 1'b1;
      send_burst   = 1'b1;
      repeat (16) begin
         send_byte(1'b1, $urandom_range(0, 1) ? BYTE_END : 8'($urandom_range(1, 255)), 1'b1);
      end
      retarget();

      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 11) == 0) retarget();
         if ($urandom_range(0, 7) == 0) send_noise();
         else run_search();
      end

      push = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0) begin
         $display("fat_directory_entry_matcher_core regression: pass");
      end else begin
         $display("fat_directory_entry_matcher_core regression: fail");
      end
      $finish;
   end

   initial begin
      int unsigned gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         gap = draw_gap(take_burst);
         if (gap != 0) begin
            pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop = 1'b1;
         do @(posedge clock); while (empty);
         board.check_outcome(rsp_status, rsp_first_cluster, rsp_size_bytes, rsp_entry_index);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
      end
      $display("fat_directory_entry_matcher_core regression: fail");
      $finish;
   end

endmodule
